>>> hdl/erls_pkg.sv
package erls_pkg;

    // Table size and the index width that follows from it.
    localparam int NUM_SLOTS = 8;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Field widths fixed by the request and result formats.
    localparam int OP_W    = 2;
    localparam int SLOT_W  = 3;
    localparam int TICK_W  = 16;

    // Reset value of the epoch length register.
    localparam logic [TICK_W-1:0] EPOCH_RESET = 16'd10;

    // Request opcodes; code 3 is unused and only reports the state as is.
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_SET   = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [SLOT_W-1:0] slot;
        logic              in_use;
        logic [SLOT_W-1:0] parent;
    } t_req;

    typedef struct packed {
        logic              switch_now;
        logic [SLOT_W-1:0] old_slot;
        logic [SLOT_W-1:0] new_slot;
        logic              none_found;
        logic [TICK_W-1:0] tick_value;
    } t_res;

    // One entry of the slot table.
    typedef struct packed {
        logic              in_use;
        logic [SLOT_W-1:0] parent;
    } t_slot_entry;

    // Access bundle from the controller to the slot memory.
    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        t_slot_entry       wr_data;
        logic [IDX_W-1:0]  rd_addr;
    } t_mem_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_PICK
    } t_state;

    // True when a slot field addresses an entry of the table.
    function automatic logic slot_ok(input logic [SLOT_W-1:0] s);
        return (32'(s) < NUM_SLOTS);
    endfunction

    // Round-robin successor of a table index.
    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(NUM_SLOTS - 1)) ? '0 : i + 1'b1;
    endfunction

endpackage

>>> hdl/erls_slot_mem.sv
module erls_slot_mem
    import erls_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_mem_req    i_mem_req,
    output t_slot_entry o_rd_data
);

    t_slot_entry             r_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]    r_valid;
    t_slot_entry             r_rd_data;
    logic                    r_rd_valid;

    // Per-entry valid bits stand for the cleared table after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_mem_req.wr_en) begin
            r_valid[i_mem_req.wr_addr] <= 1'b1;
        end
    end

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_mem_req.wr_en) begin
            r_mem[i_mem_req.wr_addr] <= i_mem_req.wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rd_data  <= r_mem[i_mem_req.rd_addr];
        r_rd_valid <= r_valid[i_mem_req.rd_addr];
    end

    // An entry never written reads as the reset value.
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

>>> hdl/erls_sched_ctrl.sv
module erls_sched_ctrl
    import erls_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_req              i_req,
    input  logic [TICK_W-1:0] i_epoch_ticks,
    output t_mem_req          o_mem_req,
    input  t_slot_entry       i_rd_data,
    output logic              o_strobe,
    output t_res              o_result
);

    t_state               r_state, n_state;
    logic [TICK_W-1:0]    r_tick, n_tick;
    logic [SLOT_W-1:0]    r_cur, n_cur;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic                 r_ld, n_ld;
    logic [IDX_W-1:0]     r_ld_idx, n_ld_idx;
    logic [NUM_SLOTS-1:0] r_use, n_use;
    logic [NUM_SLOTS-1:0] r_par, n_par;
    logic [IDX_W-1:0]     r_cand, n_cand;
    logic [IDX_W-1:0]     r_steps, n_steps;
    logic                 r_strobe, n_strobe;
    t_res                 r_res, n_res;

    logic                 accept;
    logic                 hit;
    logic [SLOT_W-1:0]    cand_slot;

    assign accept    = start && (r_state == S_IDLE);
    assign busy      = (r_state != S_IDLE);
    assign hit       = r_use[r_cand] && !r_par[r_cand] && (r_cand != '0);
    assign cand_slot = SLOT_W'(r_cand);

    // Memory access: writes only from an accepted write request; read data is used
    // only while scanning, so a used read and a write never meet on the same entry.
    always_comb begin
        o_mem_req.wr_en   = accept && (i_req.opcode == OP_WRITE) && slot_ok(i_req.slot);
        o_mem_req.wr_addr = IDX_W'(i_req.slot);
        o_mem_req.wr_data = '{in_use: i_req.in_use, parent: i_req.parent};
        o_mem_req.rd_addr = r_idx;
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath.
    always_comb begin
        n_state  = r_state;
        n_tick   = r_tick;
        n_cur    = r_cur;
        n_idx    = r_idx;
        n_ld     = 1'b0;
        n_ld_idx = r_idx;
        n_use    = r_use;
        n_par    = r_par;
        n_cand   = r_cand;
        n_steps  = r_steps;
        n_strobe = 1'b0;
        n_res    = r_res;

        // Fold the entry read in the previous cycle into the leaf masks.
        if (r_ld) begin
            n_use[r_ld_idx] = i_rd_data.in_use;
            if ((r_ld_idx != '0) && i_rd_data.in_use && slot_ok(i_rd_data.parent)) begin
                n_par[IDX_W'(i_rd_data.parent)] = 1'b1;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res.switch_now = 1'b0;
                    n_res.none_found = 1'b0;
                    n_res.old_slot   = r_cur;
                    n_res.new_slot   = r_cur;
                    n_res.tick_value = r_tick;
                    priority if (i_req.opcode == OP_TICK) begin
                        if (r_tick < i_epoch_ticks) begin
                            n_tick           = r_tick + 1'b1;
                            n_res.tick_value = r_tick + 1'b1;
                            n_strobe         = 1'b1;
                        end else begin
                            // Epoch over: rebuild the leaf masks from the table.
                            n_tick  = '0;
                            n_idx   = '0;
                            n_use   = '0;
                            n_par   = '0;
                            n_state = S_SCAN;
                        end
                    end else if (i_req.opcode == OP_SET) begin
                        if (slot_ok(i_req.slot)) begin
                            n_cur          = i_req.slot;
                            n_res.new_slot = i_req.slot;
                        end
                        n_strobe = 1'b1;
                    end else begin
                        // Table writes and the unused code report the state as is.
                        n_strobe = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                n_ld     = 1'b1;
                n_ld_idx = r_idx;
                if (r_idx == IDX_W'(NUM_SLOTS - 1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DRAIN: begin
                // Last entry lands this cycle; start the search after the current slot.
                n_cand  = next_idx(IDX_W'(r_cur));
                n_steps = '0;
                n_state = S_PICK;
            end
            S_PICK: begin
                n_res.old_slot   = r_cur;
                n_res.tick_value = r_tick;
                if (hit) begin
                    n_res.switch_now = (cand_slot != r_cur);
                    n_res.none_found = 1'b0;
                    n_res.new_slot   = cand_slot;
                    n_cur            = cand_slot;
                    n_strobe         = 1'b1;
                    n_state          = S_IDLE;
                end else if (r_steps == IDX_W'(NUM_SLOTS - 1)) begin
                    n_res.switch_now = 1'b0;
                    n_res.none_found = 1'b1;
                    n_res.new_slot   = r_cur;
                    n_strobe         = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_cand  = next_idx(r_cand);
                    n_steps = r_steps + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick   <= '0;
            r_cur    <= '0;
            r_ld     <= 1'b0;
            r_strobe <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_tick   <= n_tick;
            r_cur    <= n_cur;
            r_ld     <= n_ld;
            r_strobe <= n_strobe;
            r_idx    <= n_idx;
        end
    end

    // Working registers of the scan and the result.
    always_ff @(posedge i_clk) begin
        r_ld_idx <= n_ld_idx;
        r_use    <= n_use;
        r_par    <= n_par;
        r_cand   <= n_cand;
        r_steps  <= n_steps;
        r_res    <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

>>> hdl/epoch_round_robin_leaf_scheduler_unit.sv
// A write, a set or a tick inside the epoch gives its result in the cycle after acceptance.
// A tick that ends the epoch scans the slot table through the memory read port and then
// searches round-robin, one slot a cycle. Throughput: one request per cycle for short
// requests; busy holds off requests during a decision. Reset (synchronous, active low)
// clears the slot table, tick count and current slot and sets the epoch length to 10.
// The receiver cannot stall.
module epoch_round_robin_leaf_scheduler_unit
    import erls_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_req              i_req,
    input  logic              i_cfg_we,
    input  logic [TICK_W-1:0] i_cfg_data,
    output logic              o_strobe,
    output t_res              o_result
);

    logic [TICK_W-1:0] r_epoch_ticks;
    t_mem_req          mem_req;
    t_slot_entry       rd_data;

    // Epoch length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch_ticks <= EPOCH_RESET;
        end else if (i_cfg_we) begin
            r_epoch_ticks <= i_cfg_data;
        end
    end

    erls_slot_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mem_req (mem_req),
        .o_rd_data (rd_data)
    );

    erls_sched_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req         (i_req),
        .i_epoch_ticks (r_epoch_ticks),
        .o_mem_req     (mem_req),
        .i_rd_data     (rd_data),
        .o_strobe      (o_strobe),
        .o_result      (o_result)
    );

endmodule

>>> hdl/erls_checker.sv
module erls_checker
    import erls_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_strobe,
    input t_res              o_result
);

    // Every accepted request either answers next cycle or starts a decision.
    a_accept_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_strobe || busy))
        else $error("accepted request neither answered nor started a decision");

    // A decision always ends with its result.
    a_decision_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("decision ended without a result");

    // A switch moves to a different slot and is never a failed search.
    a_switch_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.switch_now) |->
            (!o_result.none_found && (o_result.old_slot != o_result.new_slot)))
        else $error("switch result is inconsistent");

    // A failed search keeps the slot and comes at the end of an epoch.
    a_none_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.none_found) |->
            ((o_result.old_slot == o_result.new_slot) && (o_result.tick_value == '0)))
        else $error("none-found result changed the slot or the tick count");

    // Out of reset the block is idle and quiet.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_strobe))
        else $error("busy or strobe after reset");

endmodule

bind epoch_round_robin_leaf_scheduler_unit erls_checker u_erls_checker (.*);
